>>> sv/rarmt_pkg.sv
// shared types, constants and helpers of the range-add range-min tree
// no dependencies; the controller, datapath and top-level files import this package
package rarmt_pkg;

  // tree geometry
  localparam int LEAVES    = 1024;
  localparam int LEVELS    = 10;
  localparam int TREE_N    = 1 << LEVELS;
  localparam int NODE_W    = LEVELS + 1;
  localparam int IDX_W     = 11;
  localparam int LVL_W     = 4;
  localparam int MEM_DEPTH = 1 << NODE_W;
  localparam int VAL_W     = 32;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [NODE_W-1:0]       node_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [LVL_W-1:0]        lvl_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  // command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_ACCEPT,
    OP_RD,
    OP_SET1,
    OP_SET1X,
    OP_SET2,
    OP_SET3,
    OP_LEAF,
    OP_ACC,
    OP_DOWN_L,
    OP_DOWN_R,
    OP_UP,
    OP_SIB,
    OP_RCL,
    OP_RCR,
    OP_RCW,
    OP_OUT
  } op_t;

  // status returned by the datapath
  typedef struct packed {
    logic [1:0] cmd;
    logic       q_empty;
    logic       load_oob;
    logic       disjoint;
    logic       full;
    logic       leaf;
    logic       go_left;
    logic       is_left;
    logic       root;
    logic       clr_done;
    logic       out_busy;
  } stat_t;

  // signed minimum
  function automatic val_t vmin(input val_t a, input val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> sv/rarmt_if.sv
// valid/ready channel interfaces for input and result transactions
// no dependencies
interface rarmt_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [10:0]             range_lo;
  logic [10:0]             range_hi;
  logic signed [31:0]      operand_value;

  modport source (output valid, output command, output range_lo, output range_hi,
                  output operand_value, input ready);
  modport sink (input valid, input command, input range_lo, input range_hi,
                input operand_value, output ready);
endinterface

interface rarmt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] min_value;
  logic               range_empty;

  modport source (output valid, output min_value, output range_empty, input ready);
  modport sink (input valid, input min_value, input range_empty, output ready);
endinterface

>>> sv/rarmt_dpath.sv
// datapath: node memories, walk position, settle arithmetic and result register
// depends on rarmt_pkg and rarmt_if
module rarmt_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  rarmt_pkg::op_t   op,
  output rarmt_pkg::stat_t stat,
  rarmt_in_if.sink         in_chan,
  rarmt_out_if.source      out_chan
);
  import rarmt_pkg::*;

  val_t  min_mem  [MEM_DEPTH];
  val_t  pend_mem [MEM_DEPTH];
  val_t  min_rd_r, pend_rd_r;

  logic  [1:0] cmd_r;
  idx_t  lo_r, hi_r;
  val_t  opnd_r;
  node_t k_r;
  lvl_t  lvl_r;
  val_t  acc_r, mcur_r, p_r, left_r;
  node_t clr_addr_r;
  logic  out_valid_r;
  val_t  out_value_r;
  logic  out_empty_r;

  node_t child_l, child_r;
  lvl_t  shamt;
  idx_t  pos, span, l_idx, r_idx, mid;
  val_t  p_eff;
  logic  q_empty;

  logic  min_we, pend_we;
  node_t min_wa, pend_wa, min_ra, pend_ra;
  val_t  min_wd, pend_wd;

  // node span from index and level
  always_comb begin
    child_l = node_t'({k_r, 1'b1});
    child_r = child_l + node_t'(1);
    shamt   = lvl_t'(LEVELS) - lvl_r;
    pos     = idx_t'(k_r - ((node_t'(1) << lvl_r) - node_t'(1)));
    span    = idx_t'(1) << shamt;
    l_idx   = pos << shamt;
    r_idx   = l_idx + span;
    mid     = l_idx + (span >> 1);
    q_empty = (lo_r >= hi_r) || (lo_r >= idx_t'(TREE_N));
  end

  // status towards the controller
  always_comb begin
    stat.cmd      = cmd_r;
    stat.q_empty  = q_empty;
    stat.load_oob = lo_r >= idx_t'(LEAVES);
    stat.disjoint = (hi_r <= l_idx) || (r_idx <= lo_r);
    stat.full     = (lo_r <= l_idx) && (r_idx <= hi_r);
    stat.leaf     = lvl_r == lvl_t'(LEVELS);
    stat.go_left  = lo_r < mid;
    stat.is_left  = k_r[0];
    stat.root     = k_r == '0;
    stat.clr_done = &clr_addr_r;
    stat.out_busy = out_valid_r && !out_chan.ready;
  end

  // memory ports per operation
  always_comb begin
    p_eff   = pend_rd_r + ((op == OP_SET1X) ? opnd_r : val_t'(0));
    min_we  = 1'b0;
    pend_we = 1'b0;
    min_wa  = k_r;
    pend_wa = k_r;
    min_wd  = '0;
    pend_wd = '0;
    min_ra  = k_r;
    pend_ra = k_r;
    unique case (op)
      OP_CLR: begin
        min_we  = 1'b1;
        pend_we = 1'b1;
        min_wa  = clr_addr_r;
        pend_wa = clr_addr_r;
      end
      OP_SET1, OP_SET1X: begin
        min_we  = 1'b1;
        min_wd  = min_rd_r + p_eff;
        pend_we = 1'b1;
        pend_ra = child_l;
      end
      OP_SET2: begin
        pend_we = 1'b1;
        pend_wa = child_l;
        pend_wd = pend_rd_r + p_r;
        pend_ra = child_r;
      end
      OP_SET3: begin
        pend_we = 1'b1;
        pend_wa = child_r;
        pend_wd = pend_rd_r + p_r;
      end
      OP_LEAF: begin
        min_we = 1'b1;
        min_wd = opnd_r;
      end
      OP_RCL: min_ra = child_l;
      OP_RCR: min_ra = child_r;
      OP_RCW: begin
        min_we = 1'b1;
        min_wd = vmin(left_r, min_rd_r);
      end
      default: ;
    endcase
  end

  // node memories with registered read
  always_ff @(posedge clk) begin
    if (min_we) min_mem[min_wa] <= min_wd;
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    min_rd_r  <= min_mem[min_ra];
    pend_rd_r <= pend_mem[pend_ra];
  end

  // walk position and working registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_ACCEPT: begin
        cmd_r  <= in_chan.command;
        lo_r   <= in_chan.range_lo;
        hi_r   <= in_chan.range_hi;
        opnd_r <= in_chan.operand_value;
        k_r    <= '0;
        lvl_r  <= '0;
        acc_r  <= VAL_MAX;
      end
      OP_SET1, OP_SET1X: begin
        p_r    <= p_eff;
        mcur_r <= min_rd_r + p_eff;
      end
      OP_ACC:    acc_r <= vmin(acc_r, mcur_r);
      OP_DOWN_L: begin
        k_r   <= child_l;
        lvl_r <= lvl_r + lvl_t'(1);
      end
      OP_DOWN_R: begin
        k_r   <= child_r;
        lvl_r <= lvl_r + lvl_t'(1);
      end
      OP_UP: begin
        k_r   <= (k_r - node_t'(1)) >> 1;
        lvl_r <= lvl_r - lvl_t'(1);
      end
      OP_SIB:  k_r <= k_r[0] ? k_r + node_t'(1) : k_r - node_t'(1);
      OP_RCR:  left_r <= min_rd_r;
      default: ;
    endcase
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (op == OP_CLR && !(&clr_addr_r)) begin
      clr_addr_r <= clr_addr_r + node_t'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      out_value_r <= q_empty ? VAL_MAX : acc_r;
      out_empty_r <= q_empty;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.min_value   = out_value_r;
  assign out_chan.range_empty = out_empty_r;

endmodule

>>> sv/rarmt_ctrl.sv
// controller: state machine that walks the tree one node visit at a time
// depends on rarmt_pkg
module rarmt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rarmt_pkg::stat_t stat,
  output rarmt_pkg::op_t   op
);
  import rarmt_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_START, S_RD, S_SET1, S_SET2, S_SET3, S_EVAL,
    S_RET, S_RCL, S_RCR, S_RCW, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;
  logic   sib_r, sib_nxt;

  // next state and operation
  always_comb begin
    state_nxt = state_r;
    sib_nxt   = sib_r;
    op        = OP_NONE;
    unique case (state_r)
      S_CLR: begin
        op = OP_CLR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && ready_r) begin
          op        = OP_ACCEPT;
          sib_nxt   = 1'b0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        unique case (stat.cmd)
          CMD_LOAD:  state_nxt = stat.load_oob ? S_IDLE : S_RD;
          CMD_ADD:   state_nxt = S_RD;
          CMD_QUERY: state_nxt = stat.q_empty ? S_OUT : S_RD;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_RD: begin
        op        = OP_RD;
        state_nxt = S_SET1;
      end
      S_SET1: begin
        op = (stat.cmd == CMD_ADD && stat.full && !stat.disjoint) ? OP_SET1X : OP_SET1;
        state_nxt = stat.leaf ? S_EVAL : S_SET2;
      end
      S_SET2: begin
        op        = OP_SET2;
        state_nxt = S_SET3;
      end
      S_SET3: begin
        op        = OP_SET3;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stat.cmd == CMD_LOAD) begin
          priority if (sib_r) begin
            op        = OP_UP;
            state_nxt = S_RCL;
          end else if (stat.leaf) begin
            op        = OP_LEAF;
            state_nxt = S_RET;
          end else begin
            op        = stat.go_left ? OP_DOWN_L : OP_DOWN_R;
            state_nxt = S_RD;
          end
        end else begin
          priority if (stat.disjoint) begin
            state_nxt = S_RET;
          end else if (stat.full) begin
            if (stat.cmd == CMD_QUERY) op = OP_ACC;
            state_nxt = S_RET;
          end else begin
            op        = OP_DOWN_L;
            state_nxt = S_RD;
          end
        end
      end
      S_RET: begin
        priority if (stat.root) begin
          state_nxt = (stat.cmd == CMD_QUERY) ? S_OUT : S_IDLE;
        end else if (stat.cmd == CMD_LOAD) begin
          op        = OP_SIB;
          sib_nxt   = 1'b1;
          state_nxt = S_RD;
        end else if (stat.is_left) begin
          op        = OP_SIB;
          state_nxt = S_RD;
        end else begin
          op        = OP_UP;
          state_nxt = (stat.cmd == CMD_ADD) ? S_RCL : S_RET;
        end
      end
      S_RCL: begin
        op        = OP_RCL;
        state_nxt = S_RCR;
      end
      S_RCR: begin
        op        = OP_RCR;
        state_nxt = S_RCW;
      end
      S_RCW: begin
        op        = OP_RCW;
        sib_nxt   = 1'b0;
        state_nxt = S_RET;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ready_nxt = state_nxt == S_IDLE;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ready_r <= 1'b0;
      sib_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      sib_r   <= sib_nxt;
    end
  end

  assign in_ready = ready_r;

endmodule

>>> sv/range_add_range_min_tree_unit.sv
// Lazy segment tree over 1024 signed 32-bit leaves with load, range add and
// range minimum. After reset a clearing sweep zeroes both node memories; no
// transaction is accepted during it. Each transaction then walks the tree one
// node at a time: a node visit is a memory read and a settle of the pending add
// into the node and both children, done in steps since each memory has one read
// port, and a parent recompute reads both children and writes their minimum.
// An empty query skips the walk.
// A finished result waits in an output register while the next transaction runs.
// depends on rarmt_pkg, rarmt_if, rarmt_ctrl and rarmt_dpath
module range_add_range_min_tree_unit (
  input logic         clk,
  input logic         rst_n,
  rarmt_in_if.sink    in_chan,
  rarmt_out_if.source out_chan
);
  import rarmt_pkg::*;

  op_t   op;
  stat_t stat;

  // controller
  rarmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .op       (op)
  );

  // datapath
  rarmt_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .stat     (stat),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
